>>> rtl/cps_pkg.sv
// Shared types, constants and codes for the charge percent scaler.
package cps_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int RAW_W     = 15;
  localparam int PCT_W     = 7;
  localparam int NUM_W     = 29;   // (raw - empty) * 10000 fits in 29 bits
  localparam int DEN_W     = 15;
  localparam int DIV_CNT_W = 5;    // counts NUM_W quotient bits
  localparam int Q_LO_W    = 14;   // quotient bits kept below the clamp point
  localparam int PROD_W    = 28;
  localparam int FMT1_W    = 21;   // 16-bit word times 25

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Arithmetic constants
  localparam logic [RAW_W-1:0]  PCT_MUL     = 15'd100;
  localparam logic [4:0]        FMT1_MUL    = 5'd25;     // 1953125 / 10000000 = 25 / 128
  localparam int                FMT1_SHIFT  = 7;
  localparam logic [13:0]       SCALE_NUM   = 14'd10000;
  localparam logic [Q_LO_W-1:0] RECIP       = 14'd10486; // ceil(2^20 / 100)
  localparam int                RECIP_SHIFT = 20;
  localparam logic [NUM_W-1:0]  PCT_CLAMP_Q = 29'd10100; // quotient giving more than 100
  localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_NONE    = 7'd0;

  // Register reset values
  localparam logic [RAW_W-1:0] EMPTY_RST   = 15'd30;
  localparam logic [RAW_W-1:0] DFULL_RST   = 15'd9950;
  localparam logic [RAW_W-1:0] FLOOR_RST   = 15'd9400;
  localparam logic [RAW_W-1:0] CEILING_RST = 15'd10050;
  localparam logic [RAW_W-1:0] MARGIN_RST  = 15'd50;

  // Register indexes
  typedef enum logic [2:0] {
    REG_BATTERY_FORMAT = 3'd0,
    REG_EMPTY_POINT    = 3'd1,
    REG_USE_FIXED_FULL = 3'd2,
    REG_DEFAULT_FULL   = 3'd3,
    REG_FULL_FLOOR     = 3'd4,
    REG_FULL_CEILING   = 3'd5,
    REG_FULL_MARGIN    = 3'd6
  } reg_idx_t;

  // Item opcodes
  localparam logic OP_READING = 1'b0;
  localparam logic OP_FULL    = 1'b1;

  typedef struct packed {
    logic             battery_format;
    logic [RAW_W-1:0] empty_point;
    logic             use_fixed_full;
    logic [RAW_W-1:0] default_full;
    logic [RAW_W-1:0] full_floor;
    logic [RAW_W-1:0] full_ceiling;
    logic [RAW_W-1:0] full_margin;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_STORE,
    ST_FULL,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PCT_ZERO,
    PCT_FULL,
    PCT_QUOT
  } pct_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     raw_we;
    logic     prep;
    logic     div_start;
    logic     recip;
    logic     pct_we;
    pct_sel_t pct_sel;
    logic     full_we;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic raw_le_empty;
    logic full_le_empty;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/cps_in_if.sv
// Input channel: one gauge reading or charger-full event per word.
interface cps_in_if;
  import cps_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] charge_high_byte;
  logic [BYTE_W-1:0] charge_low_byte;

  modport source (output valid, opcode, charge_high_byte, charge_low_byte, input ready);
  modport sink   (input valid, opcode, charge_high_byte, charge_low_byte, output ready);
endinterface

>>> rtl/cps_out_if.sv
// Result channel: raw charge, percent and full point per word.
interface cps_out_if;
  import cps_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_charge;
  logic [PCT_W-1:0] charge_percent;
  logic [RAW_W-1:0] full_point;

  modport source (output valid, raw_charge, charge_percent, full_point, input ready);
  modport sink   (input valid, raw_charge, charge_percent, full_point, output ready);
endinterface

>>> rtl/cps_regs.sv
// APB configuration register file of the charge percent scaler.
module cps_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cps_pkg::ADDR_W-1:0] paddr,
  input  logic [cps_pkg::DATA_W-1:0] pwdata,
  output logic [cps_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output cps_pkg::cfg_t             cfg
);
  import cps_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.battery_format <= 1'b0;
      cfg_r.empty_point    <= EMPTY_RST;
      cfg_r.use_fixed_full <= 1'b0;
      cfg_r.default_full   <= DFULL_RST;
      cfg_r.full_floor     <= FLOOR_RST;
      cfg_r.full_ceiling   <= CEILING_RST;
      cfg_r.full_margin    <= MARGIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BATTERY_FORMAT: cfg_r.battery_format <= pwdata[0];
        REG_EMPTY_POINT:    cfg_r.empty_point    <= pwdata[RAW_W-1:0];
        REG_USE_FIXED_FULL: cfg_r.use_fixed_full <= pwdata[0];
        REG_DEFAULT_FULL:   cfg_r.default_full   <= pwdata[RAW_W-1:0];
        REG_FULL_FLOOR:     cfg_r.full_floor     <= pwdata[RAW_W-1:0];
        REG_FULL_CEILING:   cfg_r.full_ceiling   <= pwdata[RAW_W-1:0];
        REG_FULL_MARGIN:    cfg_r.full_margin    <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_BATTERY_FORMAT: prdata = DATA_W'(cfg_r.battery_format);
      REG_EMPTY_POINT:    prdata = DATA_W'(cfg_r.empty_point);
      REG_USE_FIXED_FULL: prdata = DATA_W'(cfg_r.use_fixed_full);
      REG_DEFAULT_FULL:   prdata = DATA_W'(cfg_r.default_full);
      REG_FULL_FLOOR:     prdata = DATA_W'(cfg_r.full_floor);
      REG_FULL_CEILING:   prdata = DATA_W'(cfg_r.full_ceiling);
      REG_FULL_MARGIN:    prdata = DATA_W'(cfg_r.full_margin);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> rtl/cps_div.sv
// Restoring divider, one quotient bit per cycle.
module cps_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cps_pkg::NUM_W-1:0] dividend,
  input  logic [cps_pkg::DEN_W-1:0] divisor,
  output logic                     busy,
  output logic [cps_pkg::NUM_W-1:0] quotient
);
  import cps_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     dvd_r, dvd_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     dsr_r, dsr_nxt;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;

  // Shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem_r, dvd_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(NUM_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DEN_W-1:0];
      dvd_nxt = {dvd_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

>>> rtl/cps_dp.sv
// Datapath: decode, scaling, full-point update and output register.
module cps_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cps_pkg::cfg_t             cfg,
  input  logic [cps_pkg::BYTE_W-1:0] in_hi,
  input  logic [cps_pkg::BYTE_W-1:0] in_lo,
  input  cps_pkg::cmd_t             cmd,
  output cps_pkg::stat_t            stat,
  cps_out_if.source                 out_ch
);
  import cps_pkg::*;

  logic [BYTE_W-1:0] hi_r, lo_r;
  logic [RAW_W-1:0]  last_raw_r, adapt_full_r;
  logic [PCT_W-1:0]  last_pct_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic              raw_le_r, full_le_r, over_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  logic [RAW_W-1:0]  out_raw_r, out_full_r;
  logic [PCT_W-1:0]  out_pct_r;

  logic [FMT1_W-1:0] fmt1_prod;
  logic [RAW_W-1:0]  hi100, lo100, raw_dec;
  logic [RAW_W-1:0]  full_sel, diff;
  logic [NUM_W-1:0]  num_nxt, quot;
  logic              div_busy;
  logic [PCT_W-1:0]  pct_q, pct_nxt;
  logic [RAW_W-1:0]  full_nxt;
  logic [RAW_W:0]    floor_plus;

  // Charge bytes to hundredths of a percent
  always_comb begin
    fmt1_prod = FMT1_W'({hi_r, lo_r}) * FMT1_W'(FMT1_MUL);
    hi100     = RAW_W'(hi_r) * PCT_MUL;
    lo100     = RAW_W'(lo_r) * PCT_MUL;
    if (cfg.battery_format) begin
      raw_dec = RAW_W'(fmt1_prod >> FMT1_SHIFT);
    end else begin
      raw_dec = hi100 + RAW_W'(lo100 >> BYTE_W);
    end
  end

  // Scaling operands
  assign full_sel = cfg.use_fixed_full ? cfg.default_full : adapt_full_r;
  assign diff     = last_raw_r - cfg.empty_point;
  assign num_nxt  = NUM_W'(diff) * NUM_W'(SCALE_NUM);

  cps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Quotient / 100 by reciprocal, clamped to 100
  assign pct_q = over_r ? PCT_MAX : prod_r[RECIP_SHIFT +: PCT_W];

  always_comb begin
    case (cmd.pct_sel)
      PCT_ZERO: pct_nxt = PCT_NONE;
      PCT_FULL: pct_nxt = PCT_MAX;
      PCT_QUOT: pct_nxt = pct_q;
      default:  pct_nxt = PCT_NONE;
    endcase
  end

  // Adaptive full point from the stored raw charge
  always_comb begin
    floor_plus = {1'b0, cfg.full_floor} + {1'b0, cfg.full_margin};
    if (last_raw_r < cfg.full_floor) begin
      full_nxt = cfg.full_floor;
    end else if (last_raw_r > cfg.full_ceiling) begin
      full_nxt = (cfg.full_ceiling > cfg.full_margin) ?
                 cfg.full_ceiling - cfg.full_margin : '0;
    end else if ({1'b0, last_raw_r} > floor_plus) begin
      full_nxt = last_raw_r - cfg.full_margin;
    end else begin
      full_nxt = cfg.full_floor;
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= '0;
      adapt_full_r <= DFULL_RST;
      last_pct_r   <= '0;
    end else begin
      if (cmd.raw_we) begin
        last_raw_r <= raw_dec;
      end
      if (cmd.pct_we) begin
        last_pct_r <= pct_nxt;
      end
      if (cmd.full_we) begin
        adapt_full_r <= full_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hi_r <= in_hi;
      lo_r <= in_lo;
    end
    if (cmd.prep) begin
      num_r    <= num_nxt;
      den_r    <= full_sel - cfg.empty_point;
      raw_le_r <= last_raw_r <= cfg.empty_point;
      full_le_r <= full_sel <= cfg.empty_point;
    end
    if (cmd.recip) begin
      over_r <= quot >= PCT_CLAMP_Q;
      prod_r <= PROD_W'(quot[Q_LO_W-1:0]) * PROD_W'(RECIP);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_raw_r  <= last_raw_r;
      out_pct_r  <= last_pct_r;
      out_full_r <= adapt_full_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.raw_charge     = out_raw_r;
  assign out_ch.charge_percent = out_pct_r;
  assign out_ch.full_point     = out_full_r;

  assign stat.raw_le_empty  = raw_le_r;
  assign stat.full_le_empty = full_le_r;
  assign stat.div_busy      = div_busy;
  assign stat.out_free      = !out_valid_r || out_ch.ready;

endmodule

>>> rtl/cps_ctrl.sv
// Controller state machine sequencing one word at a time.
module cps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_ready,
  output cps_pkg::cmd_t  cmd,
  input  cps_pkg::stat_t stat
);
  import cps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.pct_sel = PCT_ZERO;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_opcode == OP_FULL) ? ST_FULL : ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.raw_we = 1'b1;
        state_nxt  = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.raw_le_empty) begin
          cmd.pct_we  = 1'b1;
          cmd.pct_sel = PCT_ZERO;
          state_nxt   = ST_FINISH;
        end else if (stat.full_le_empty) begin
          cmd.pct_we  = 1'b1;
          cmd.pct_sel = PCT_FULL;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.recip = 1'b1;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.pct_we  = 1'b1;
        cmd.pct_sel = PCT_QUOT;
        state_nxt   = ST_FINISH;
      end
      ST_FULL: begin
        cmd.full_we = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register has room
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/charge_percent_scaler.sv
// Top level of the charge percent scaler: config registers, controller, datapath.
//
// in_ch carries one word per item: opcode 0 is a gauge reading (two charge
// bytes), opcode 1 a charger-full event. out_ch returns one word per item:
// the stored raw charge, the percent of the last reading and the adaptive
// full point. The APB port (psel ... pready) writes and reads the seven
// configuration registers at byte address 4*index; pready is always high.
// Items are handled one at a time. A reading whose scale needs the divide
// runs through the bit-serial divider; a reading at or below empty, or with
// full not above empty, skips the divide, and a charger-full event updates
// the adaptive full point instead. Results sit in an output register, so
// in_ch accepts the next word while a result still waits; a stalled out_ch
// holds its word and the controller waits before loading the next one.
// Synchronous reset loads the register defaults, clears raw charge and
// percent and sets the adaptive full point to 9950.
module charge_percent_scaler (
  input  logic                      clk,
  input  logic                      rst_n,
  cps_in_if.sink                    in_ch,
  cps_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cps_pkg::ADDR_W-1:0] paddr,
  input  logic [cps_pkg::DATA_W-1:0] pwdata,
  output logic [cps_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import cps_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  cps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cps_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_hi  (in_ch.charge_high_byte),
    .in_lo  (in_ch.charge_low_byte),
    .cmd    (cmd),
    .stat   (stat),
    .out_ch (out_ch)
  );

  assign in_ch.ready = in_ready;

  // One word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // Percent never exceeds 100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.charge_percent <= PCT_MAX))
    else $error("charge percent above 100");

  // Output is loaded only once the previous word is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output word overwritten");

endmodule

>>> dv/cps_checker.sv
// Checker for the charge percent scaler: predicts every result word and compares it.
module cps_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  cps_in_if                          in_ch,
  cps_out_if                         out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [cps_pkg::ADDR_W-1:0] paddr,
  input  logic [cps_pkg::DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending,
  output int                         checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cps_pkg::*;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [PCT_W-1:0] pct;
    logic [RAW_W-1:0] full;
  } charge_word_t;

  // Shadow copy of the registers and the block's state
  cfg_t             cfg;
  logic [RAW_W-1:0] stored_raw;
  logic [PCT_W-1:0] stored_pct;
  logic [RAW_W-1:0] adapt_full;

  charge_word_t expected_words[$];
  charge_word_t exp_w;
  charge_word_t got_w;
  int           fail_total;
  int           words_seen;

  // Gauge bytes to hundredths of a percent
  function automatic logic [RAW_W-1:0] decode_charge(input logic fmt,
                                                     input logic [BYTE_W-1:0] hi,
                                                     input logic [BYTE_W-1:0] lo);
    longint unsigned word;
    longint unsigned raw;
    word = {hi, lo};
    if (fmt)
      raw = (word * 64'd1953125) / 64'd10000000;
    else
      raw = longint'(hi) * 100 + (longint'(lo) * 100) / 256;
    return raw[RAW_W-1:0];
  endfunction

  // Raw charge to a whole percent between empty and full
  function automatic logic [PCT_W-1:0] scale_to_percent(input logic [RAW_W-1:0] raw,
                                                        input cfg_t c,
                                                        input logic [RAW_W-1:0] afull);
    int unsigned r;
    int unsigned e;
    int unsigned f;
    int unsigned pct;
    r = raw;
    e = c.empty_point;
    f = c.use_fixed_full ? c.default_full : afull;
    if (r <= e)
      return 7'd0;
    if (f <= e)
      return 7'd100;
    pct = (((r - e) * 10000) / (f - e)) / 100;
    if (pct > 100)
      pct = 100;
    return pct[PCT_W-1:0];
  endfunction

  // New adaptive full point on a charger-full event
  function automatic logic [RAW_W-1:0] next_full_point(input logic [RAW_W-1:0] raw,
                                                       input cfg_t c);
    int unsigned r;
    int unsigned fl;
    int unsigned ce;
    int unsigned mg;
    int unsigned res;
    r  = raw;
    fl = c.full_floor;
    ce = c.full_ceiling;
    mg = c.full_margin;
    if (r < fl)
      res = fl;
    else if (r > ce)
      res = (ce > mg) ? ce - mg : 0;
    else if (r > fl + mg)
      res = r - mg;
    else
      res = fl;
    return res[RAW_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg = '{battery_format: 1'b0, empty_point: EMPTY_RST, use_fixed_full: 1'b0,
              default_full: DFULL_RST, full_floor: FLOOR_RST,
              full_ceiling: CEILING_RST, full_margin: MARGIN_RST};
      stored_raw = '0;
      stored_pct = '0;
      adapt_full = DFULL_RST;
      expected_words.delete();
    end else begin
      // result side: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        got_w = '{out_ch.raw_charge, out_ch.charge_percent, out_ch.full_point};
        if (expected_words.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result word: raw %0d pct %0d full %0d",
                   $time, got_w.raw, got_w.pct, got_w.full);
        end else begin
          exp_w = expected_words.pop_front();
          words_seen++;
          if (got_w !== exp_w) begin
            fail_total++;
            $write("%0t: mismatch: expected raw %0d pct %0d full %0d, ",
                   $time, exp_w.raw, exp_w.pct, exp_w.full);
            $display("got raw %0d pct %0d full %0d",
                     got_w.raw, got_w.pct, got_w.full);
          end
        end
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_BATTERY_FORMAT: cfg.battery_format = pwdata[0];
          REG_EMPTY_POINT:    cfg.empty_point    = pwdata[RAW_W-1:0];
          REG_USE_FIXED_FULL: cfg.use_fixed_full = pwdata[0];
          REG_DEFAULT_FULL:   cfg.default_full   = pwdata[RAW_W-1:0];
          REG_FULL_FLOOR:     cfg.full_floor     = pwdata[RAW_W-1:0];
          REG_FULL_CEILING:   cfg.full_ceiling   = pwdata[RAW_W-1:0];
          REG_FULL_MARGIN:    cfg.full_margin    = pwdata[RAW_W-1:0];
          default: ;
        endcase
      end

      // input side: predict the result word
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_READING) begin
          stored_raw = decode_charge(cfg.battery_format, in_ch.charge_high_byte,
                                     in_ch.charge_low_byte);
          stored_pct = scale_to_percent(stored_raw, cfg, adapt_full);
        end else begin
          adapt_full = next_full_point(stored_raw, cfg);
        end
        expected_words.push_back('{stored_raw, stored_pct, adapt_full});
      end
    end
    mismatches <= fail_total;
    pending    <= expected_words.size();
    checked    <= words_seen;
  end

endmodule

>>> dv/tb.sv
// Testbench top for the charge percent scaler: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cps_pkg::*;

  localparam logic [2:0] REG_UNMAPPED    = 3'd7;
  localparam int         ROUNDS          = 10;
  localparam int         WORDS_PER_ROUND = 200;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   mismatches;
  int   pending;
  int   checked;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   readings_sent;
  int   full_events_sent;
  int   settings_applied;
  cfg_t cur_cfg;

  cps_in_if  in_if();
  cps_out_if out_if();

  charge_percent_scaler i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cps_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #4 clk = ~clk;

  // result receiver, stalls at random
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one APB write: setup, access, then back to idle
  task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_write(REG_BATTERY_FORMAT, DATA_W'(c.battery_format));
    cfg_write(REG_EMPTY_POINT,    DATA_W'(c.empty_point));
    cfg_write(REG_USE_FIXED_FULL, DATA_W'(c.use_fixed_full));
    cfg_write(REG_DEFAULT_FULL,   DATA_W'(c.default_full));
    cfg_write(REG_FULL_FLOOR,     DATA_W'(c.full_floor));
    cfg_write(REG_FULL_CEILING,   DATA_W'(c.full_ceiling));
    cfg_write(REG_FULL_MARGIN,    DATA_W'(c.full_margin));
    cur_cfg = c;
    settings_applied++;
  endtask

  // stop sending, wait until every predicted word has come back, then settle
  task automatic wait_drained(input int settle);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // push one word through the input channel, with an optional gap first
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] hi,
                           input logic [BYTE_W-1:0] lo);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.opcode           <= op;
    in_if.charge_high_byte <= hi;
    in_if.charge_low_byte  <= lo;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_READING)
      readings_sent++;
    else
      full_events_sent++;
  endtask

  // register value for one random setting style
  function automatic logic [RAW_W-1:0] pick_point(input int kind);
    if (kind == 1)
      return RAW_W'($urandom);
    if (kind == 2)
      return RAW_W'($urandom_range(0, 25599));
    case ($urandom_range(2))
      0:       return '0;
      1:       return 15'd25599;
      default: return '1;
    endcase
  endfunction

  initial begin
    cfg_t               c;
    int                 kind;
    int                 target;
    int                 word;
    logic               op;
    logic [BYTE_W-1:0]  hi;
    logic [BYTE_W-1:0]  lo;

    rst_n                  <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_if.valid            <= 1'b0;
    in_if.opcode           <= OP_READING;
    in_if.charge_high_byte <= '0;
    in_if.charge_low_byte  <= '0;
    send_idle_pct = 30;
    recv_idle_pct = 62;
    cur_cfg = '{battery_format: 1'b0, empty_point: EMPTY_RST, use_fixed_full: 1'b0,
                default_full: DFULL_RST, full_floor: FLOOR_RST,
                full_ceiling: CEILING_RST, full_margin: MARGIN_RST};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, floor / ceiling / margin edges of the full point
    send_word(OP_FULL,    8'd0,   8'd0);    // raw below floor
    send_word(OP_READING, 8'd0,   8'd0);
    send_word(OP_READING, 8'd0,   8'd77);   // raw right at empty
    send_word(OP_READING, 8'd0,   8'd80);   // just above empty
    send_word(OP_READING, 8'd94,  8'd0);    // raw at floor
    send_word(OP_FULL,    8'd94,  8'd0);
    send_word(OP_READING, 8'd94,  8'd128);  // floor plus margin
    send_word(OP_FULL,    8'd0,   8'd0);
    send_word(OP_READING, 8'd94,  8'd52);   // inside floor margin band
    send_word(OP_FULL,    8'd0,   8'd0);
    send_word(OP_READING, 8'd100, 8'd128);  // raw at ceiling
    send_word(OP_FULL,    8'd0,   8'd0);
    send_word(OP_READING, 8'd101, 8'd0);    // above ceiling
    send_word(OP_FULL,    8'd0,   8'd0);
    send_word(OP_READING, 8'd255, 8'd255);  // clamps to 100
    send_word(OP_READING, 8'd50,  8'd0);

    // directed: 1/512 format, fixed full at max, zero floor and margin
    wait_drained(4);
    apply_config('{battery_format: 1'b1, empty_point: '0, use_fixed_full: 1'b1,
                   default_full: '1, full_floor: '0, full_ceiling: '1, full_margin: '0});
    cfg_write(REG_UNMAPPED, $urandom);
    send_word(OP_READING, 8'd255, 8'd255);
    send_word(OP_READING, 8'd0,   8'd1);
    send_word(OP_READING, 8'd1,   8'd0);
    send_word(OP_FULL,    8'd0,   8'd0);

    // directed: empty at top of range, full below empty
    wait_drained(4);
    apply_config('{battery_format: 1'b0, empty_point: 15'd25599, use_fixed_full: 1'b1,
                   default_full: '0, full_floor: '0, full_ceiling: '1, full_margin: '0});
    send_word(OP_READING, 8'd255, 8'd255);
    send_word(OP_READING, 8'd0,   8'd0);

    // directed: full not above empty, ceiling below margin saturates to zero
    wait_drained(4);
    apply_config('{battery_format: 1'b0, empty_point: 15'd100, use_fixed_full: 1'b1,
                   default_full: 15'd50, full_floor: '0, full_ceiling: 15'd10,
                   full_margin: 15'd20});
    send_word(OP_READING, 8'd10, 8'd0);
    send_word(OP_FULL,    8'd0,  8'd0);

    // directed: adaptive full now zero, equal to empty
    wait_drained(4);
    c = cur_cfg;
    c.empty_point    = '0;
    c.use_fixed_full = 1'b0;
    apply_config(c);
    send_word(OP_READING, 8'd1, 8'd0);

    // random rounds, each under a fresh register setting
    for (int r = 0; r < ROUNDS; r++) begin
      wait_drained(4);
      if (r == 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 30;
      end else if (r == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = r % 4;
      if (kind == 0) begin
        c.empty_point  = RAW_W'($urandom_range(0, 300));
        c.full_floor   = RAW_W'($urandom_range(8500, 9800));
        c.full_ceiling = c.full_floor + RAW_W'($urandom_range(0, 1200));
        c.full_margin  = RAW_W'($urandom_range(0, 300));
        c.default_full = RAW_W'($urandom_range(9000, 10500));
      end else begin
        c.empty_point  = pick_point(kind);
        c.full_floor   = pick_point(kind);
        c.full_ceiling = pick_point(kind);
        c.full_margin  = pick_point(kind);
        c.default_full = pick_point(kind);
      end
      c.battery_format = 1'($urandom_range(1));
      c.use_fixed_full = 1'($urandom_range(1));
      apply_config(c);

      for (int n = 0; n < WORDS_PER_ROUND; n++) begin
        // hold off mid-round until the block has drained
        if (n == WORDS_PER_ROUND / 2) begin
          wait_drained(0);
        end
        op = ($urandom_range(99) < 20) ? OP_FULL : OP_READING;
        lo = BYTE_W'($urandom);
        if ($urandom_range(1)) begin
          hi = BYTE_W'($urandom);
        end else begin
          // aim the reading near one of the interesting points
          case ($urandom_range(4))
            0:       target = cur_cfg.empty_point;
            1:       target = cur_cfg.full_floor;
            2:       target = cur_cfg.full_ceiling;
            3:       target = cur_cfg.default_full;
            default: target = cur_cfg.full_floor + cur_cfg.full_margin;
          endcase
          target += $urandom_range(600) - 300;
          if (target < 0)
            target = 0;
          if (cur_cfg.battery_format) begin
            word = target * 128 / 25;
            if (word > 65535)
              word = 65535;
            hi = BYTE_W'(word >> 8);
          end else begin
            hi = (target / 100 > 255) ? 8'd255 : BYTE_W'(target / 100);
          end
        end
        send_word(op, hi, lo);
      end
    end

    wait_drained(40);
    $display("Sent %0d readings and %0d charger-full events under %0d register settings,",
             readings_sent, full_events_sent, settings_applied);
    $display("with both sides stalling; %0d result words compared, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> charge_percent_scaler.f
rtl/cps_pkg.sv
rtl/cps_in_if.sv
rtl/cps_out_if.sv
rtl/cps_regs.sv
rtl/cps_div.sv
rtl/cps_dp.sv
rtl/cps_ctrl.sv
rtl/charge_percent_scaler.sv
dv/cps_checker.sv
dv/tb.sv
